// ===== sv/radix2_real_fft_core_defines.svh =====
// assertion macros shared by the checker
`ifndef RADIX2_REAL_FFT_CORE_DEFINES_SVH
`define RADIX2_REAL_FFT_CORE_DEFINES_SVH
// assert that a condition implies a property on the same edge
`define R2F_ASSERT_IMP(label, c, a, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (c) |-> (a)) else $error(msg);
// assert that a condition implies a property on the next edge
`define R2F_ASSERT_NXT(label, c, a, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (c) |=> (a)) else $error(msg);
`endif

// ===== sv/r2fft_pkg.sv =====
// package: constants, types and twiddle rom for the radix-2 fft core
package r2fft_pkg;
  localparam int POINTS_DEF = 64;
  localparam int TW_FRAC = 17;
  localparam int IN_W = 24;
  localparam int DATA_W = 32;

  localparam logic [0:0] REG_DIRECTION = 1'b0;
  localparam logic [0:0] REG_COMPLEX = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_REV_RD, ST_REV_WR, ST_BF_RD, ST_BF_MUL, ST_BF_WR,
    ST_SP_RD, ST_SP_MUL, ST_SP_WR, ST_DC_RD, ST_DC_WR, ST_EMIT_RD, ST_EMIT
  } state_t;

  // sine in q1.17, 128 steps per turn, quarter wave table
  function automatic logic signed [18:0] sine_q(input logic [4:0] r, input logic full);
    logic [17:0] v;
    begin
      if (full) v = 18'd131072;
      else begin
        case (r)
          5'd0: v = 18'd0;      5'd1: v = 18'd6431;   5'd2: v = 18'd12847;
          5'd3: v = 18'd19232;  5'd4: v = 18'd25571;  5'd5: v = 18'd31848;
          5'd6: v = 18'd38048;  5'd7: v = 18'd44157;  5'd8: v = 18'd50159;
          5'd9: v = 18'd56041;  5'd10: v = 18'd61787; 5'd11: v = 18'd67384;
          5'd12: v = 18'd72820; 5'd13: v = 18'd78079; 5'd14: v = 18'd83151;
          5'd15: v = 18'd88023; 5'd16: v = 18'd92682; 5'd17: v = 18'd97118;
          5'd18: v = 18'd101320; 5'd19: v = 18'd105278; 5'd20: v = 18'd108982;
          5'd21: v = 18'd112424; 5'd22: v = 18'd115595; 5'd23: v = 18'd118488;
          5'd24: v = 18'd121095; 5'd25: v = 18'd123410; 5'd26: v = 18'd125428;
          5'd27: v = 18'd127144; 5'd28: v = 18'd128553; 5'd29: v = 18'd129653;
          5'd30: v = 18'd130441; 5'd31: v = 18'd130914;
          default: v = 18'd0;
        endcase
      end
      sine_q = $signed({1'b0, v});
    end
  endfunction

  function automatic logic signed [18:0] tw_sin(input logic [6:0] idx);
    logic [4:0] r;
    logic signed [18:0] m;
    begin
      r = idx[4:0];
      case (idx[6:5])
        2'd0: m = sine_q(r, 1'b0);
        2'd1: m = sine_q(5'd0 - r, r == 5'd0);
        2'd2: m = -sine_q(r, 1'b0);
        default: m = -sine_q(5'd0 - r, r == 5'd0);
      endcase
      tw_sin = m;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [50:0] v);
    begin
      if (v > 51'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -51'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[DATA_W-1:0];
    end
  endfunction
endpackage

// ===== sv/r2fft_ram.sv =====
// generic single port ram with registered read
module r2fft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== sv/radix2_real_fft_core.sv =====
// Radix-2 in-place real/complex FFT core on a frame of POINTS words.
// Input channel: first_word/second_word with valid/stall; one transaction
// carries one even/odd pair, POINTS/2 transactions make a frame.
// Config channel: cfg_valid/cfg_ready, cfg_index 0 is direction, 1 is
// complex_mode; write only while idle.
// Output channel: out_first/out_second/out_last with out_valid/out_stall,
// POINTS/2 pairs per frame in index order, out_last on the final pair.
// The transform runs on one shared butterfly unit over a two-word-wide
// store. Each butterfly and each split pair reads both operands,
// multiplies, then writes both results; a bit-reversal swap reads both
// words and writes them back crossed, and an index left in place is only
// read. Input stall is high while the transform runs and while results
// drain.
// Reset clears the load counter, registers and the sequencer; the store
// is not cleared. When the receiver stalls, the held pair stays stable
// and the sequencer waits.
module radix2_real_fft_core #(
  parameter int POINTS = r2fft_pkg::POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [r2fft_pkg::IN_W-1:0]   first_word,
  input  logic signed [r2fft_pkg::IN_W-1:0]   second_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [0:0]                      cfg_index,
  input  logic [0:0]                      cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [r2fft_pkg::DATA_W-1:0] out_first,
  output logic signed [r2fft_pkg::DATA_W-1:0] out_second,
  output logic                            out_last
);
  import r2fft_pkg::*;

  localparam int HALF = POINTS / 2;
  localparam int AW = $clog2(HALF);
  localparam int ROM_STEP = 128 / POINTS;

  state_t state, state_next;
  logic direction, complex_mode;
  logic [AW-1:0] cnt;     // load / emit / bitrev / split index
  logic [AW-1:0] len;     // butterfly half span (one-hot)
  logic [AW-1:0] bfi;     // butterfly number in stage
  logic sgn_neg;

  logic we;
  logic [AW-1:0] addr;
  logic [2*DATA_W-1:0] wdata, rdata;
  logic [2*DATA_W-1:0] hold;  // first operand read

  r2fft_ram #(.WIDTH(2*DATA_W), .DEPTH(HALF)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // bit reverse
  function automatic logic [AW-1:0] brev(input logic [AW-1:0] v);
    for (int b = 0; b < AW; b++) brev[b] = v[AW-1-b];
  endfunction

  // butterfly indices: a = group*2len + m, c = a + len
  logic [AW-1:0] lmask, m_idx, a_idx, c_idx, hi_part;
  always_comb begin
    lmask = len - 1'b1;
    m_idx = bfi & lmask;
    hi_part = (bfi & ~lmask) << 1;
    a_idx = hi_part | m_idx;
    c_idx = a_idx | len;
  end

  // twiddle index m*128/(2len), or cnt*128/POINTS in the split pass
  logic [6:0] tw_idx;
  always_comb begin
    tw_idx = '0;
    for (int b = 0; b < AW; b++)
      if (len[b]) tw_idx = 7'((32'(m_idx) * (64 >> b)));
    if (state == ST_SP_RD || state == ST_SP_MUL || state == ST_SP_WR)
      tw_idx = 7'(32'(cnt) * ROM_STEP);
  end

  logic signed [18:0] wr, wsn, wi;
  always_comb begin
    wr = tw_sin(tw_idx + 7'd32);
    wsn = tw_sin(tw_idx);
    wi = sgn_neg ? -wsn : wsn;
  end

  // shared products
  logic signed [DATA_W-1:0] ar, ai, br, bi;
  logic signed [34:0] h2r, h2i;
  logic signed [34:0] opr, opi;
  logic signed [55:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [55:0] t1, t2;
  always_comb begin
    ar = hold[2*DATA_W-1:DATA_W]; ai = hold[DATA_W-1:0];
    br = rdata[2*DATA_W-1:DATA_W]; bi = rdata[DATA_W-1:0];
    h2r = sgn_neg ? -(35'(ai) + 35'(bi)) : (35'(ai) + 35'(bi));
    h2i = sgn_neg ? (35'(ar) - 35'(br)) : -(35'(ar) - 35'(br));
    if (state == ST_BF_MUL) begin
      opr = 35'(br); opi = 35'(bi);
    end else begin
      opr = h2r; opi = h2i;
    end
  end

  logic signed [55:0] pr_q, pi_q;
  // products stay put through both writes
  always_ff @(posedge clk) begin
    if (state == ST_BF_MUL || state == ST_SP_MUL) begin
      p_rr <= 56'(wr * opr);
      p_ii <= 56'(wi * opi);
      p_ri <= 56'(wr * opi);
      p_ir <= 56'(wi * opr);
    end
  end
  always_comb begin
    t1 = p_rr - p_ii;
    t2 = p_ri + p_ir;
    pr_q = (t1 + 56'sd65536) >>> TW_FRAC;
    pi_q = (t2 + 56'sd65536) >>> TW_FRAC;
  end

  logic signed [DATA_W-1:0] bf_ar, bf_ai, bf_cr, bf_ci;
  logic signed [DATA_W-1:0] sp_ar, sp_ai, sp_cr, sp_ci;
  logic signed [55:0] sr, di;
  logic signed [DATA_W-1:0] xr_q, xi_q;
  always_ff @(posedge clk) begin
    if (state == ST_BF_MUL || state == ST_SP_MUL) begin
      xr_q <= br; xi_q <= bi;
    end
  end
  always_comb begin
    bf_ar = sat32(51'(ar) + 51'(pr_q));
    bf_ai = sat32(51'(ai) + 51'(pi_q));
    bf_cr = sat32(51'(ar) - 51'(pr_q));
    bf_ci = sat32(51'(ai) - 51'(pi_q));
    sr = (56'(ar) + 56'(xr_q)) <<< TW_FRAC;
    di = (56'(ai) - 56'(xi_q)) <<< TW_FRAC;
    sp_ar = sat32(51'((sr + t1 + 56'sd131072) >>> (TW_FRAC + 1)));
    sp_ai = sat32(51'((di + t2 + 56'sd131072) >>> (TW_FRAC + 1)));
    sp_cr = sat32(51'((sr - t1 + 56'sd131072) >>> (TW_FRAC + 1)));
    sp_ci = sat32(51'((-di + t2 + 56'sd131072) >>> (TW_FRAC + 1)));
  end

  // dc / nyquist pack
  logic signed [32:0] dsum, ddif;
  logic signed [DATA_W-1:0] dc0, dc1;
  always_comb begin
    dsum = 33'(ar) + 33'(ai);
    ddif = 33'(ar) - 33'(ai);
    if (direction) begin
      dc0 = sat32(51'((dsum + 33'sd1) >>> 1));
      dc1 = sat32(51'((ddif + 33'sd1) >>> 1));
    end else begin
      dc0 = sat32(51'(dsum));
      dc1 = sat32(51'(ddif));
    end
  end

  logic second_wr;  // set for the second read or write of a pair; butterflies write a, then c
  logic [AW-1:0] part;
  always_comb begin
    part = HALF[AW-1:0] - cnt;
  end

  logic in_acc, out_acc;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != ST_LOAD);
  assign cfg_ready = (state == ST_LOAD);

  // sequencer
  logic [AW-1:0] cnt_next, len_next, bfi_next;
  logic second_next, sgn_next;
  always_comb begin
    state_next = state;
    cnt_next = cnt; len_next = len; bfi_next = bfi;
    second_next = second_wr; sgn_next = sgn_neg;
    we = 1'b0; addr = cnt; wdata = hold;
    case (state)
      ST_LOAD: begin
        addr = cnt;
        wdata = {DATA_W'(first_word), DATA_W'(second_word)};
        if (in_acc) begin
          we = 1'b1;
          cnt_next = cnt + 1'b1;
          if (cnt == AW'(HALF - 1)) begin
            cnt_next = '0;
            if (complex_mode) begin
              sgn_next = direction; state_next = ST_REV_RD;
            end else if (!direction) begin
              sgn_next = 1'b0; state_next = ST_REV_RD;
            end else begin
              sgn_next = 1'b1; state_next = ST_SP_RD; cnt_next = AW'(1);
            end
          end
        end
      end
      ST_REV_RD: begin
        // read cnt, then read partner; the cnt word is captured into hold during the partner read
        addr = second_wr ? brev(cnt) : cnt;
        if (brev(cnt) <= cnt) begin
          second_next = 1'b0;
          cnt_next = cnt + 1'b1;
          if (cnt == AW'(HALF - 1)) begin
            cnt_next = '0; state_next = ST_BF_RD;
            len_next = AW'(1); bfi_next = '0;
          end
        end else if (!second_wr) second_next = 1'b1;
        else begin
          second_next = 1'b0; state_next = ST_REV_WR;
        end
      end
      ST_REV_WR: begin
        we = 1'b1;
        if (!second_wr) begin
          addr = cnt; wdata = rdata; second_next = 1'b1;
        end else begin
          addr = brev(cnt); wdata = hold; second_next = 1'b0;
          cnt_next = cnt + 1'b1;
          state_next = ST_REV_RD;
          if (cnt == AW'(HALF - 1)) begin
            cnt_next = '0; state_next = ST_BF_RD;
            len_next = AW'(1); bfi_next = '0;
          end
        end
      end
      ST_BF_RD: begin
        addr = second_wr ? c_idx : a_idx;
        if (!second_wr) second_next = 1'b1;
        else begin
          second_next = 1'b0; state_next = ST_BF_MUL;
        end
      end
      ST_BF_MUL: begin
        addr = c_idx;
        state_next = ST_BF_WR;
      end
      ST_BF_WR: begin
        we = 1'b1;
        if (!second_wr) begin
          addr = a_idx; wdata = {bf_ar, bf_ai}; second_next = 1'b1;
        end else begin
          addr = c_idx; wdata = {bf_cr, bf_ci}; second_next = 1'b0;
          bfi_next = bfi + 1'b1;
          state_next = ST_BF_RD;
          if (bfi == AW'(HALF / 2 - 1)) begin
            bfi_next = '0;
            len_next = len << 1;
            if (len[AW-1]) begin
              if (complex_mode || direction) state_next = ST_EMIT_RD;
              else begin
                state_next = ST_SP_RD; cnt_next = AW'(1); sgn_next = 1'b0;
              end
            end
          end
        end
      end
      ST_SP_RD: begin
        addr = second_wr ? part : cnt;
        if (cnt == AW'(HALF / 2)) begin
          addr = '0; state_next = ST_DC_RD; second_next = 1'b0;
        end else if (!second_wr) second_next = 1'b1;
        else begin
          second_next = 1'b0; state_next = ST_SP_MUL;
        end
      end
      ST_SP_MUL: begin
        addr = part;
        state_next = ST_SP_WR;
      end
      ST_SP_WR: begin
        we = 1'b1;
        if (!second_wr) begin
          addr = cnt; wdata = {sp_ar, sp_ai}; second_next = 1'b1;
        end else begin
          addr = part; wdata = {sp_cr, sp_ci}; second_next = 1'b0;
          cnt_next = cnt + 1'b1; state_next = ST_SP_RD;
        end
      end
      ST_DC_RD: begin
        addr = '0;
        if (!second_wr) second_next = 1'b1;
        else begin
          second_next = 1'b0; state_next = ST_DC_WR;
        end
      end
      ST_DC_WR: begin
        we = 1'b1; addr = '0; wdata = {dc0, dc1};
        cnt_next = '0;
        if (direction) begin
          state_next = ST_REV_RD; sgn_next = 1'b1;
        end else state_next = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        addr = cnt;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        addr = cnt;
        if (out_acc) begin
          cnt_next = cnt + 1'b1;
          state_next = ST_EMIT_RD;
          if (cnt == AW'(HALF - 1)) begin
            cnt_next = '0; state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // first-read operand capture
  always_ff @(posedge clk) begin
    if ((state == ST_REV_RD || state == ST_BF_RD || state == ST_SP_RD ||
         state == ST_DC_RD) && second_wr)
      hold <= rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt <= '0; len <= AW'(1); bfi <= '0;
      second_wr <= 1'b0; sgn_neg <= 1'b0;
      direction <= 1'b0; complex_mode <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next; len <= len_next; bfi <= bfi_next;
      second_wr <= second_next; sgn_neg <= sgn_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIRECTION: direction <= cfg_data[0];
          REG_COMPLEX: complex_mode <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid = (state == ST_EMIT);
  assign out_first = rdata[2*DATA_W-1:DATA_W];
  assign out_second = rdata[DATA_W-1:0];
  assign out_last = (cnt == AW'(HALF - 1));
endmodule

// ===== sv/r2fft_checker.sv =====
// port-level checker for the fft core, bound to the top level
`include "radix2_real_fft_core_defines.svh"
module r2fft_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic cfg_ready,
  input logic out_valid,
  input logic out_stall,
  input logic out_last,
  input logic [31:0] out_first
);
  // no loads while results are pending
  `R2F_ASSERT_IMP(a_no_in_while_out, out_valid, in_stall, "input open during emit")
  // config only taken while inputs are taken
  `R2F_ASSERT_IMP(a_cfg_idle, cfg_ready, !in_stall, "config open while busy")
  // stalled result holds
  `R2F_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_first),
                  "stalled result changed")
  // after the last pair the block reopens
  `R2F_ASSERT_NXT(a_last_reopen, out_valid && !out_stall && out_last, !in_stall,
                  "not ready after frame")
endmodule

bind radix2_real_fft_core r2fft_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .cfg_ready(cfg_ready), .out_valid(out_valid), .out_stall(out_stall),
  .out_last(out_last), .out_first(out_first)
);
